>>> design/adcs_pkg.sv
// ----------------------------------------------------------------------------
// adcs_pkg
// Types, constants and helper functions shared by the ADC conversion blocks.
// ----------------------------------------------------------------------------
package adcs_pkg;

	// ADC resolution and derived full scale
	localparam int AdcBits  = 12;
	localparam int FsW      = 16;
	localparam logic [FsW-1:0] AdcFs = FsW'((1 << AdcBits) - 1);
	localparam int ShR      = (AdcBits >= 12) ? AdcBits - 12 : 0;
	localparam int ShL      = (AdcBits < 12) ? 12 - AdcBits : 0;

	// shared divider geometry
	localparam int DvdW     = 48;
	localparam int DvsW     = 16;
	localparam int DivSteps = DvdW / 2;
	localparam int DivCntW  = $clog2(DivSteps + 1);

	// configuration register indexes
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam logic [CfgIdxW-1:0] REG_VREF_CAL_CODE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_VREF_CAL_MV   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TS_CAL_LOW    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TS_CAL_HIGH   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_TS_CAL_MV     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_TEMP_OFFSET   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_TEMP_DECIM    = 3'd6;

	// state of charge curve, segment i runs from SocMv[i+1] to SocMv[i]
	localparam int SocPts = 7;
	localparam logic [11:0] SocMv  [SocPts] = '{12'd3200, 12'd3000, 12'd2800,
		12'd2600, 12'd2400, 12'd2200, 12'd2000};
	localparam logic [6:0]  SocPct [SocPts] = '{7'd100, 7'd100, 7'd85, 7'd60,
		7'd35, 7'd10, 7'd0};
	localparam logic [7:0]  SocSegMv = 8'd200;

	typedef struct packed {
		logic        motor_enable;
		logic [11:0] vref_sample;
		logic [11:0] motor_sample;
		logic [11:0] temp_sample;
		logic [11:0] vbat_sample;
	} adcs_in_t;

	typedef struct packed {
		logic               motor_valid;
		logic [13:0]        motor_current_ma;
		logic               temp_valid;
		logic signed [11:0] temperature_tenths;
		logic [13:0]        battery_mv;
		logic [6:0]         charge_level;
	} adcs_out_t;

	// classified item between front and back
	typedef struct packed {
		logic     meas;
		adcs_in_t item;
	} adcs_task_t;

	typedef struct packed {
		logic [11:0]       vrefint_cal_code;
		logic [11:0]       vrefint_cal_mv;
		logic [11:0]       ts_cal_low_code;
		logic [11:0]       ts_cal_high_code;
		logic [11:0]       ts_cal_mv;
		logic signed [9:0] temp_offset_tenths;
		logic [15:0]       temp_decimation;
	} adcs_cfg_t;

	typedef struct packed {
		logic [6:0] sl;
		logic [4:0] dsl;
		logic [11:0] vl;
	} adcs_seg_t;

	typedef enum logic [3:0] {
		B_IDLE, B_SUP, B_MVM, B_CUR, B_SCL, B_TMP, B_MVB, B_SOC, B_DONE
	} adcs_bstate_t;

	// sample limited to the converter resolution
	function automatic logic [11:0] adc_mask(input logic [11:0] x);
		return x & AdcFs[11:0];
	endfunction

	// sample rescaled to 12 bits
	function automatic logic [11:0] to12(input logic [11:0] x);
		logic [15:0] t;
		t = ({4'd0, adc_mask(x)} >> ShR) << ShL;
		return t[11:0];
	endfunction

	// curve segment holding v (2000 < v < 3200)
	function automatic adcs_seg_t soc_seg(input logic [25:0] v);
		adcs_seg_t s;
		s = '0;
		for (int i = SocPts - 2; i >= 0; i--) begin
			if (v >= {14'd0, SocMv[i+1]}) begin
				s.vl  = SocMv[i+1];
				s.sl  = SocPct[i+1];
				s.dsl = 5'(SocPct[i] - SocPct[i+1]);
			end
		end
		return s;
	endfunction

endpackage

>>> design/adcs_div.sv
// ----------------------------------------------------------------------------
// adcs_div
// Shared unsigned divider, radix 4 restoring, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module adcs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [adcs_pkg::DvdW-1:0]  dividend,
	input  logic [adcs_pkg::DvsW-1:0]  divisor,
	output logic                       done,
	output logic [adcs_pkg::DvdW-1:0]  quotient
);
	import adcs_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DivCntW-1:0]  cnt_q;
	logic [DvdW-1:0]     quo_q;
	logic [DvsW-1:0]     rem_q;
	logic [DvsW-1:0]     dvs_q;
	logic [DvdW-1:0]     quo_nx;
	logic [DvsW-1:0]     rem_nx;

	// two restoring steps per cycle
	always_comb begin
		logic [DvsW:0] r;
		quo_nx = quo_q;
		rem_nx = rem_q;
		for (int k = 0; k < 2; k++) begin
			r = {rem_nx, quo_nx[DvdW-1]};
			quo_nx = {quo_nx[DvdW-2:0], 1'b0};
			if (r >= {1'b0, dvs_q}) begin
				r = r - {1'b0, dvs_q};
				quo_nx[0] = 1'b1;
			end
			rem_nx = r[DvsW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

>>> design/adcs_front.sv
// ----------------------------------------------------------------------------
// adcs_front
// Accepts ticks, decides whether the tick measures temperature and battery.
// ----------------------------------------------------------------------------
module adcs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  adcs_pkg::adcs_in_t   in_item,
	input  logic [15:0]          temp_decimation,
	input  logic                 q_full,
	output logic                 push,
	output adcs_pkg::adcs_task_t push_task
);
	import adcs_pkg::*;

	logic [15:0] dcnt_q;
	logic        meas;
	logic [15:0] dcnt_base;

	// decimation decision
	always_comb begin
		meas = !in_item.motor_enable || (temp_decimation == '0) ||
			(dcnt_q >= temp_decimation);
		dcnt_base = meas ? 16'd0 : dcnt_q;
	end

	assign in_stall       = q_full;
	assign push           = in_valid && !q_full;
	assign push_task.meas = meas;
	assign push_task.item = in_item;

	// tick counter, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= 16'hFFFF;
		end else if (push) begin
			if (!in_item.motor_enable)
				dcnt_q <= '0;
			else if (dcnt_base != 16'hFFFF)
				dcnt_q <= dcnt_base + 1'b1;
			else
				dcnt_q <= dcnt_base;
		end
	end
endmodule

>>> design/adcs_queue.sv
// ----------------------------------------------------------------------------
// adcs_queue
// Two-entry item queue between front and back.
// ----------------------------------------------------------------------------
module adcs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  adcs_pkg::adcs_task_t push_task,
	output logic                 full,
	input  logic                 pop,
	output logic                 q_valid,
	output adcs_pkg::adcs_task_t q_task
);
	import adcs_pkg::*;

	adcs_task_t ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_task  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_task;
	end
endmodule

>>> design/adcs_back.sv
// ----------------------------------------------------------------------------
// adcs_back
// Conversion sequencer: supply, current, temperature, battery, charge.
// ----------------------------------------------------------------------------
module adcs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  adcs_pkg::adcs_cfg_t  cfg,
	input  logic                 q_valid,
	input  adcs_pkg::adcs_task_t q_task,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output adcs_pkg::adcs_out_t  out_item
);
	import adcs_pkg::*;

	adcs_bstate_t state_q, state_nx;
	adcs_task_t   task_q;
	logic         started_q;
	logic [23:0]  supply_q;
	logic [23:0]  mv_q;
	logic [13:0]  ma_q;
	logic [35:0]  scaled_q;
	logic signed [11:0] temp_q;
	logic [25:0]  bat_q;
	logic [6:0]   soc_q;
	logic         out_valid_q;
	adcs_out_t    out_q;

	logic             div_start;
	logic [DvdW-1:0]  div_dvd;
	logic [DvsW-1:0]  div_dvs;
	logic             div_done;
	logic [DvdW-1:0]  div_quo;

	logic [11:0]  vref12, m12, t12, v12;
	logic signed [12:0] den;
	logic signed [36:0] diff;
	logic signed [47:0] num;
	logic         neg;
	logic signed [49:0] tq;
	logic signed [49:0] tsum;
	logic signed [11:0] tclamp;
	logic signed [49:0] tbase;
	logic [29:0]  ma_full;
	adcs_seg_t    seg;
	logic         out_free;
	logic         adv;

	assign vref12 = to12(task_q.item.vref_sample);
	assign m12    = adc_mask(task_q.item.motor_sample);
	assign t12    = to12(task_q.item.temp_sample);
	assign v12    = adc_mask(task_q.item.vbat_sample);
	assign out_free = !out_valid_q || !out_stall;

	// temperature numerator, sign and clamp; current and charge segment
	always_comb begin
		den  = $signed({1'b0, cfg.ts_cal_high_code}) - $signed({1'b0, cfg.ts_cal_low_code});
		diff = $signed({1'b0, scaled_q}) - $signed({25'd0, cfg.ts_cal_low_code});
		num  = 48'(diff) * 48'sd1000;
		neg  = num[47] ^ den[12];
		tq   = neg ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
		tbase = (den == '0) ? 50'sd0 : tq;
		tsum = tbase + 50'sd300 + 50'(cfg.temp_offset_tenths);
		if (tsum < -50'sd1000)
			tclamp = -12'sd1000;
		else if (tsum > 50'sd2000)
			tclamp = 12'sd2000;
		else
			tclamp = tsum[11:0];
		ma_full = div_quo[29:0];
		seg     = soc_seg(bat_q);
	end

	// next state and divider requests
	always_comb begin
		state_nx  = state_q;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = DvsW'(1);
		pop       = 1'b0;
		adv       = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					pop      = 1'b1;
					state_nx = B_SUP;
				end
			end
			B_SUP: begin
				div_dvd = DvdW'(cfg.vrefint_cal_mv * cfg.vrefint_cal_code);
				div_dvs = DvsW'(vref12);
				if (vref12 == '0)
					adv = 1'b1;
				else if (!started_q)
					div_start = 1'b1;
				else if (div_done)
					adv = 1'b1;
				if (adv)
					state_nx = B_MVM;
			end
			B_MVM: begin
				div_dvd = DvdW'(supply_q * m12);
				div_dvs = AdcFs;
				if (!task_q.item.motor_enable) begin
					state_nx = task_q.meas ? B_SCL : B_DONE;
				end else if (!started_q) begin
					div_start = 1'b1;
				end else if (div_done) begin
					adv      = 1'b1;
					state_nx = B_CUR;
				end
			end
			B_CUR: begin
				div_dvd = DvdW'({6'd0, mv_q} * 30'd50);
				div_dvs = DvsW'(11);
				if (!started_q) begin
					div_start = 1'b1;
				end else if (div_done) begin
					adv      = 1'b1;
					state_nx = task_q.meas ? B_SCL : B_DONE;
				end
			end
			B_SCL: begin
				div_dvd = DvdW'(t12 * supply_q);
				div_dvs = DvsW'(cfg.ts_cal_mv);
				if (cfg.ts_cal_mv == '0)
					adv = 1'b1;
				else if (!started_q)
					div_start = 1'b1;
				else if (div_done)
					adv = 1'b1;
				if (adv)
					state_nx = B_TMP;
			end
			B_TMP: begin
				div_dvd = num[47] ? DvdW'(-num) : DvdW'(num);
				div_dvs = den[12] ? DvsW'(-den) : DvsW'(den);
				if (den == '0)
					adv = 1'b1;
				else if (!started_q)
					div_start = 1'b1;
				else if (div_done)
					adv = 1'b1;
				if (adv)
					state_nx = B_MVB;
			end
			B_MVB: begin
				div_dvd = DvdW'(supply_q * v12);
				div_dvs = AdcFs;
				if (!started_q) begin
					div_start = 1'b1;
				end else if (div_done) begin
					adv      = 1'b1;
					state_nx = B_SOC;
				end
			end
			B_SOC: begin
				div_dvd = DvdW'((bat_q - {14'd0, seg.vl}) * {21'd0, seg.dsl});
				div_dvs = DvsW'(SocSegMv);
				if (bat_q >= 26'(SocMv[0]) || bat_q <= 26'(SocMv[SocPts-1]))
					adv = 1'b1;
				else if (!started_q)
					div_start = 1'b1;
				else if (div_done)
					adv = 1'b1;
				if (adv)
					state_nx = B_DONE;
			end
			B_DONE: begin
				if (out_free) begin
					adv      = 1'b1;
					state_nx = B_IDLE;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	adcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (div_start)
				started_q <= 1'b1;
			else if (adv || state_nx != state_q)
				started_q <= 1'b0;
			if (state_q == B_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath captures
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop)
					task_q <= q_task;
				ma_q <= '0;
			end
			B_SUP: begin
				if (adv)
					supply_q <= (vref12 == '0) ? {12'd0, cfg.ts_cal_mv} : div_quo[23:0];
			end
			B_MVM: begin
				if (adv)
					mv_q <= div_quo[23:0];
			end
			B_CUR: begin
				if (adv)
					ma_q <= (ma_full > 30'd16383) ? 14'd16383 : ma_full[13:0];
			end
			B_SCL: begin
				if (adv)
					scaled_q <= (cfg.ts_cal_mv == '0) ? {24'd0, t12} : div_quo[35:0];
			end
			B_TMP: begin
				if (adv)
					temp_q <= tclamp;
			end
			B_MVB: begin
				if (adv)
					bat_q <= 26'(div_quo[23:0]) * 26'd3;
			end
			B_SOC: begin
				if (adv) begin
					if (bat_q >= 26'(SocMv[0]))
						soc_q <= SocPct[0];
					else if (bat_q <= 26'(SocMv[SocPts-1]))
						soc_q <= SocPct[SocPts-1];
					else
						soc_q <= seg.sl + div_quo[6:0];
				end
			end
			B_DONE: begin
				if (out_free) begin
					out_q.motor_valid        <= task_q.item.motor_enable;
					out_q.motor_current_ma   <= ma_q;
					out_q.temp_valid         <= task_q.meas;
					out_q.temperature_tenths <= task_q.meas ? temp_q : 12'sd0;
					out_q.battery_mv <= !task_q.meas ? 14'd0 :
						(bat_q > 26'd12000) ? 14'd12000 : bat_q[13:0];
					out_q.charge_level <= task_q.meas ? soc_q : 7'd0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule

>>> design/adc_sensor_conversion_pipeline.sv
// ----------------------------------------------------------------------------
// adc_sensor_conversion_pipeline
// Calibrated ADC conversion: motor current, temperature, battery and charge.
// ----------------------------------------------------------------------------
// Usage:
//  in channel (in_valid/in_stall/in_item): one sampling tick per item.
//  out channel (out_valid/out_stall/out_item): one result item per tick.
//  cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//  always ready; indexes past the register list are dropped.
//  The front passes each tick into a two-entry queue; the back
//  works it through a shared radix-4 divider, up to seven divisions a
//  tick (supply, motor mV, current, temperature scale, temperature,
//  battery mV, charge); the queue takes new ticks while the back works
//  on an earlier one.
//  Reset returns the calibration registers to their defaults, empties the
//  queue and the output register, and arms the decimation counter so the
//  first motor-on tick measures at once.
//  When the receiver stalls, the result holds in the output register, the
//  back finishes the next tick and waits, and the queue then fills and
//  stalls the input.
// ----------------------------------------------------------------------------
module adc_sensor_conversion_pipeline (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  adcs_pkg::adcs_in_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output adcs_pkg::adcs_out_t            out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [adcs_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [adcs_pkg::CfgDataW-1:0]  cfg_data
);
	import adcs_pkg::*;

	adcs_cfg_t  cfg_q;
	logic       push, q_full, pop, q_valid;
	adcs_task_t push_task, q_task;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vrefint_cal_code   <= 12'd1500;
			cfg_q.vrefint_cal_mv     <= 12'd3600;
			cfg_q.ts_cal_low_code    <= 12'd1034;
			cfg_q.ts_cal_high_code   <= 12'd1370;
			cfg_q.ts_cal_mv          <= 12'd3000;
			cfg_q.temp_offset_tenths <= 10'sd0;
			cfg_q.temp_decimation    <= 16'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VREF_CAL_CODE: cfg_q.vrefint_cal_code   <= cfg_data[11:0];
				REG_VREF_CAL_MV:   cfg_q.vrefint_cal_mv     <= cfg_data[11:0];
				REG_TS_CAL_LOW:    cfg_q.ts_cal_low_code    <= cfg_data[11:0];
				REG_TS_CAL_HIGH:   cfg_q.ts_cal_high_code   <= cfg_data[11:0];
				REG_TS_CAL_MV:     cfg_q.ts_cal_mv          <= cfg_data[11:0];
				REG_TEMP_OFFSET:   cfg_q.temp_offset_tenths <= cfg_data[9:0];
				REG_TEMP_DECIM:    cfg_q.temp_decimation    <= cfg_data;
				default: ;
			endcase
		end
	end

	adcs_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_item         (in_item),
		.temp_decimation (cfg_q.temp_decimation),
		.q_full          (q_full),
		.push            (push),
		.push_task       (push_task)
	);

	adcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_task (push_task),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_task    (q_task)
	);

	adcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_task    (q_task),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);
endmodule

>>> design/adcs_chk.sv
// ----------------------------------------------------------------------------
// adcs_chk
// Port-level checks on the conversion block's result items.
// ----------------------------------------------------------------------------
module adcs_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input adcs_pkg::adcs_out_t out_item
);
	import adcs_pkg::*;

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result item changed");

	// motor off gives zero current
	a_motor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.motor_valid |-> out_item.motor_current_ma == '0)
		else $error("current without motor");

	// no measurement gives zero fields
	a_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.temp_valid |->
		out_item.temperature_tenths == '0 && out_item.battery_mv == '0 &&
		out_item.charge_level == '0)
		else $error("measurement fields without measurement");

	// saturation ranges
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.charge_level <= 7'd100 &&
		out_item.battery_mv <= 14'd12000 &&
		out_item.temperature_tenths >= -12'sd1000 &&
		out_item.temperature_tenths <= 12'sd2000)
		else $error("result out of range");
endmodule

bind adc_sensor_conversion_pipeline adcs_chk u_adcs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

>>> test/adc_sensor_conversion_pipeline_tb.sv
// ----------------------------------------------------------------------------
// adc_sensor_conversion_pipeline_tb
// Drives sampling ticks under several calibration settings and checks each
// result item against a cycle-free integer model of the conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_sensor_conversion_pipeline_tb;
	import adcs_pkg::*;

	localparam int StallLimit = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	adcs_in_t in_item;
	logic out_valid;
	logic out_stall;
	adcs_out_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// calibration mirror and decimation counter
	adcs_cfg_t cal;
	int unsigned decim_cnt;

	adcs_in_t pending_ticks[$];
	adcs_out_t expected_results[$];
	int send_idle;
	int recv_idle;
	int errors;
	int quiet_cycles;

	adc_sensor_conversion_pipeline i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// battery voltage to state of charge on the alkaline curve
	function automatic longint charge_pct(input longint v);
		longint pts_mv[7] = '{3200, 3000, 2800, 2600, 2400, 2200, 2000};
		longint pts_pct[7] = '{100, 100, 85, 60, 35, 10, 0};
		if (v >= 3200) return 100;
		if (v <= 2000) return 0;
		for (int i = 0; i < 6; i++) begin
			if (v >= pts_mv[i+1])
				return pts_pct[i+1] + (v - pts_mv[i+1]) * (pts_pct[i] - pts_pct[i+1])
					/ (pts_mv[i] - pts_mv[i+1]);
		end
		return 0;
	endfunction

	// expected result of one tick; advances the decimation counter
	function automatic adcs_out_t convert_tick(input adcs_in_t t);
		adcs_out_t r;
		longint supply, ma, scaled, den, temp, bat;
		bit meas;
		r = '0;
		if (t.vref_sample == 0) supply = cal.ts_cal_mv;
		else supply = longint'(cal.vrefint_cal_mv) * cal.vrefint_cal_code / t.vref_sample;
		meas = 1'b1;
		if (t.motor_enable) begin
			ma = supply * t.motor_sample / 4095 * 50 / 11;
			r.motor_valid = 1'b1;
			r.motor_current_ma = (ma > 16383) ? 14'd16383 : 14'(ma);
			meas = (cal.temp_decimation == 0) || (decim_cnt >= cal.temp_decimation);
			if (meas) decim_cnt = 0;
			if (decim_cnt < 16'hFFFF) decim_cnt++;
		end else begin
			decim_cnt = 0;
		end
		if (meas) begin
			if (cal.ts_cal_mv != 0) scaled = longint'(t.temp_sample) * supply / cal.ts_cal_mv;
			else scaled = t.temp_sample;
			den = longint'(cal.ts_cal_high_code) - longint'(cal.ts_cal_low_code);
			if (den != 0) temp = (scaled - longint'(cal.ts_cal_low_code)) * 1000 / den + 300;
			else temp = 300;
			temp += cal.temp_offset_tenths;
			if (temp < -1000) temp = -1000;
			if (temp > 2000) temp = 2000;
			bat = 3 * (supply * t.vbat_sample / 4095);
			r.temp_valid = 1'b1;
			r.temperature_tenths = 12'(temp);
			r.battery_mv = (bat > 12000) ? 14'd12000 : 14'(bat);
			r.charge_level = 7'(charge_pct(bat));
		end
		return r;
	endfunction

	// input driver: one item per handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(convert_tick(in_item));
			if (!in_valid || !in_stall) begin
				if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_item <= pending_ticks.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor, receiver stalls and watchdog
	always @(posedge clk or negedge arst_n) begin
		adcs_out_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_item);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (out_item.motor_valid !== exp_r.motor_valid ||
						out_item.motor_current_ma !== exp_r.motor_current_ma ||
						out_item.temp_valid !== exp_r.temp_valid ||
						out_item.temperature_tenths !== exp_r.temperature_tenths ||
						out_item.battery_mv !== exp_r.battery_mv ||
						out_item.charge_level !== exp_r.charge_level) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r, out_item);
						errors++;
					end
				end
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// register write, mirrored into the calibration copy
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_VREF_CAL_CODE: cal.vrefint_cal_code = val[11:0];
			REG_VREF_CAL_MV: cal.vrefint_cal_mv = val[11:0];
			REG_TS_CAL_LOW: cal.ts_cal_low_code = val[11:0];
			REG_TS_CAL_HIGH: cal.ts_cal_high_code = val[11:0];
			REG_TS_CAL_MV: cal.ts_cal_mv = val[11:0];
			REG_TEMP_OFFSET: cal.temp_offset_tenths = val[9:0];
			REG_TEMP_DECIM: cal.temp_decimation = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input int code, input int mv, input int lo, input int hi,
		input int tmv, input int ofs, input int dec);
		write_reg(REG_VREF_CAL_CODE, CfgDataW'(code));
		write_reg(REG_VREF_CAL_MV, CfgDataW'(mv));
		write_reg(REG_TS_CAL_LOW, CfgDataW'(lo));
		write_reg(REG_TS_CAL_HIGH, CfgDataW'(hi));
		write_reg(REG_TS_CAL_MV, CfgDataW'(tmv));
		write_reg(REG_TEMP_OFFSET, CfgDataW'(ofs));
		write_reg(REG_TEMP_DECIM, CfgDataW'(dec));
	endtask

	// wait until every result is in, then let the back end settle
	task automatic drain();
		do @(posedge clk);
		while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (250) @(posedge clk);
	endtask

	function automatic adcs_in_t mk(input bit me, input int v, input int m,
		input int t, input int b);
		adcs_in_t x;
		x.motor_enable = me;
		x.vref_sample = 12'(v);
		x.motor_sample = 12'(m);
		x.temp_sample = 12'(t);
		x.vbat_sample = 12'(b);
		return x;
	endfunction

	// random ticks: motor runs to exercise decimation, samples mostly plausible
	task automatic queue_random(input int n);
		bit me;
		me = 1'b0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) me = ~me;
			if ($urandom_range(3) == 0)
				pending_ticks.push_back(mk(me, $urandom, $urandom, $urandom, $urandom));
			else
				pending_ticks.push_back(mk(me, $urandom_range(1200, 2400),
					$urandom_range(0, 600), $urandom_range(700, 1800),
					$urandom_range(500, 1500)));
		end
	endtask

	initial begin
		errors = 0;
		send_idle = 13;
		recv_idle = 77;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cal = '{12'd1500, 12'd3600, 12'd1034, 12'd1370, 12'd3000, 10'sd0, 16'd10};
		decim_cnt = 16'hFFFF;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: sample extremes, zero reference, charge curve points
		pending_ticks.push_back(mk(1, 1500, 100, 1034, 1000));
		pending_ticks.push_back(mk(1, 0, 4095, 4095, 4095));
		pending_ticks.push_back(mk(1, 4095, 0, 0, 0));
		pending_ticks.push_back(mk(0, 1, 4095, 4095, 4095));
		pending_ticks.push_back(mk(0, 0, 0, 0, 0));
		pending_ticks.push_back(mk(0, 1800, 2000, 1370, 1213));
		pending_ticks.push_back(mk(0, 1800, 0, 1200, 1137));
		pending_ticks.push_back(mk(0, 1800, 0, 1200, 1062));
		pending_ticks.push_back(mk(0, 1800, 0, 1200, 910));
		pending_ticks.push_back(mk(0, 1800, 0, 1200, 758));
		pending_ticks.push_back(mk(0, 1800, 0, 1200, 700));
		for (int i = 0; i < 12; i++)
			pending_ticks.push_back(mk(1, 1500, 3000, 1100 + i, 1000));
		drain();

		// equal calibration codes, zero temperature supply, extreme offsets
		write_all(4095, 4000, 1200, 1200, 0, 500, 0);
		write_reg(3'd7, 16'hFFFF);
		queue_random(60);
		drain();
		write_all(1, 1000, 4095, 0, 4000, -500, 1);
		queue_random(60);
		drain();
		write_all(4095, 4095, 0, 4095, 1000, 0, 65535);
		queue_random(60);
		drain();

		// random settings under each idling mode
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 3) begin
				send_idle = 77;
				recv_idle = 13;
			end else if (ph == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_all($urandom_range(1300, 1700) | ($urandom_range(1) << 15),
				$urandom_range(3000, 3800), $urandom_range(900, 1100),
				$urandom_range(1250, 1500), $urandom_range(2800, 3400),
				$urandom_range(0, 1023) | ($urandom_range(63) << 10),
				$urandom_range(0, 12));
			if (ph % 3 == 2) write_reg(REG_TEMP_DECIM, CfgDataW'($urandom));
			queue_random(90);
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
design/adcs_pkg.sv
design/adcs_div.sv
design/adcs_front.sv
design/adcs_queue.sv
design/adcs_back.sv
design/adc_sensor_conversion_pipeline.sv
design/adcs_chk.sv
test/adc_sensor_conversion_pipeline_tb.sv
